[hdl/baf_pkg.sv]
// Shared types and constants for the bond angle finder.
package baf_pkg;

  localparam int unsigned AtomW = 16;

  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncClear = 1'b1;

  localparam logic StatAngle = 1'b0;
  localparam logic StatFull  = 1'b1;

  typedef logic [AtomW-1:0] atom_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic store;
    logic load_ovf;
    logic flush;
  } baf_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic pend_v;
    logic out_free;
  } baf_sts_t;

endpackage

[hdl/baf_ctrl.sv]
// Control state machine: sequences clear, table scan, store, overflow result and final flush.
module baf_ctrl
  import baf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_ready,
  input  baf_sts_t sts,
  output baf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FuncClear) begin
            cmd.clear = 1'b1;
          end else if (sts.full) begin
            cmd.load_ovf = 1'b1;
            state_nxt    = S_FLUSH;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.store = 1'b1;
          state_nxt = sts.pend_v ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/baf_dpath.sv]
// Datapath: bond memory, scan pipeline, pending angle and output register.
module baf_dpath
  import baf_pkg::*;
#(
  parameter int unsigned MAX_BONDS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  baf_cmd_t cmd,
  output baf_sts_t sts,
  input  atom_t    in_atom_first,
  input  atom_t    in_atom_second,
  output logic     out_valid,
  input  logic     out_ready,
  output atom_t    out_end_atom_one,
  output atom_t    out_center_atom,
  output atom_t    out_end_atom_two,
  output logic     out_status,
  output logic     out_last_of_run
);

  localparam int unsigned AW = $clog2(MAX_BONDS);
  localparam int unsigned CW = $clog2(MAX_BONDS + 1);

  logic [2*AtomW-1:0] mem [MAX_BONDS];
  logic [2*AtomW-1:0] rd_r;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic          cmp_v_r;
  atom_t         new_a_r;
  atom_t         new_b_r;

  logic  pend_v_r;
  atom_t pend_e1_r;
  atom_t pend_c_r;
  atom_t pend_e2_r;
  logic  pend_st_r;

  logic  out_v_r;
  atom_t out_e1_r;
  atom_t out_c_r;
  atom_t out_e2_r;
  logic  out_st_r;
  logic  out_last_r;

  atom_t oa;
  atom_t ob;
  logic  hit;
  atom_t hit_e1;
  atom_t hit_c;
  atom_t hit_e2;
  logic  out_free;
  logic  stall;
  logic  issue;
  logic  cmp_take;
  logic  push_mid;

  assign oa = rd_r[AtomW-1:0];
  assign ob = rd_r[2*AtomW-1:AtomW];

  always_comb begin
    hit    = 1'b1;
    hit_e1 = ob;
    hit_c  = oa;
    hit_e2 = new_b_r;
    if (oa == new_a_r) begin
      hit_e2 = new_b_r;
    end else if (oa == new_b_r) begin
      hit_e2 = new_a_r;
    end else if (ob == new_a_r) begin
      hit_e1 = oa;
      hit_c  = ob;
      hit_e2 = new_b_r;
    end else if (ob == new_b_r) begin
      hit_e1 = oa;
      hit_c  = ob;
      hit_e2 = new_a_r;
    end else begin
      hit = 1'b0;
    end
  end

  assign out_free = !out_v_r || out_ready;
  assign stall    = cmp_v_r && hit && pend_v_r && !out_free;
  assign issue    = cmd.scan && !stall && (idx_r != cnt_r);
  assign cmp_take = cmd.scan && cmp_v_r && hit && !stall;
  assign push_mid = cmp_take && pend_v_r;

  assign sts.full      = (cnt_r == CW'(MAX_BONDS));
  assign sts.scan_done = (idx_r == cnt_r) && !cmp_v_r;
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[cnt_r[AW-1:0]] <= {new_b_r, new_a_r};
    end
    if (issue) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      new_a_r <= in_atom_first;
      new_b_r <= in_atom_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      idx_r   <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt_r <= '0;
      end else if (cmd.store) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.start) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.start) begin
        cmp_v_r <= 1'b0;
      end else if (cmd.scan && !stall) begin
        cmp_v_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.load_ovf) begin
      pend_v_r <= 1'b1;
    end else if (cmp_take) begin
      pend_v_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ovf) begin
      pend_e1_r <= '0;
      pend_c_r  <= '0;
      pend_e2_r <= '0;
      pend_st_r <= StatFull;
    end else if (cmp_take) begin
      pend_e1_r <= hit_e1;
      pend_c_r  <= hit_c;
      pend_e2_r <= hit_e2;
      pend_st_r <= StatAngle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push_mid || cmd.flush) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || cmd.flush) begin
      out_e1_r   <= pend_e1_r;
      out_c_r    <= pend_c_r;
      out_e2_r   <= pend_e2_r;
      out_st_r   <= pend_st_r;
      out_last_r <= cmd.flush;
    end
  end

  assign out_valid        = out_v_r;
  assign out_end_atom_one = out_e1_r;
  assign out_center_atom  = out_c_r;
  assign out_end_atom_two = out_e2_r;
  assign out_status       = out_st_r;
  assign out_last_of_run  = out_last_r;

endmodule

[hdl/bond_angle_finder_unit.sv]
// Bond angle finder top level: controller plus datapath.
// An add item scans the stored bonds through the single read port of the bond
// memory, one bond per cycle unless the scan pauses. Each found angle is held
// in a pending register so the final one can carry last_of_run. The scan
// pauses when a new angle meets a pending one while the output register is
// still occupied. An add to a full table (MAX_BONDS bonds) gives one result
// with status 1. A new item is taken once the previous item's last result sits
// in the output register, or once its bond is stored when it gave no result.
module bond_angle_finder_unit
  import baf_pkg::*;
#(
  parameter int unsigned MAX_BONDS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_func,
  input  atom_t in_atom_first,
  input  atom_t in_atom_second,
  output logic  out_valid,
  input  logic  out_ready,
  output atom_t out_end_atom_one,
  output atom_t out_center_atom,
  output atom_t out_end_atom_two,
  output logic  out_status,
  output logic  out_last_of_run
);

  baf_cmd_t cmd;
  baf_sts_t sts;

  baf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  baf_dpath #(
    .MAX_BONDS (MAX_BONDS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_atom_first    (in_atom_first),
    .in_atom_second   (in_atom_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_end_atom_one (out_end_atom_one),
    .out_center_atom  (out_center_atom),
    .out_end_atom_two (out_end_atom_two),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run)
  );

`ifndef SYNTHESIS
  a_no_store_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.store && sts.full))
    else $error("bond stored into a full table");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_v)
    else $error("new item taken while an angle is still pending");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ovf |-> (sts.full && !cmd.start && !cmd.clear))
    else $error("overflow result without a full table");

  a_flush_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_valid && out_last_of_run))
    else $error("flush did not present a last result");
`endif

endmodule

[sim/bond_angle_finder_unit_tb.sv]
// Testbench for bond_angle_finder_unit: bond streams checked against a local angle predictor.
module bond_angle_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import baf_pkg::*;

  localparam int unsigned Bonds      = 64;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    logic        func;
    atom_t       first;
    atom_t       second;
    int unsigned gap;
    bit          rx_stall;
    bit          drain;
  } bond_item_t;

  typedef struct {
    atom_t end_one;
    atom_t center;
    atom_t end_two;
    logic  status;
    logic  last;
  } angle_t;

  logic  clk            = 1'b0;
  logic  rst_n          = 1'b0;
  logic  in_valid       = 1'b0;
  logic  in_ready;
  logic  in_func        = FuncAdd;
  atom_t in_atom_first  = '0;
  atom_t in_atom_second = '0;
  logic  out_valid;
  logic  out_ready      = 1'b0;
  atom_t out_end_atom_one;
  atom_t out_center_atom;
  atom_t out_end_atom_two;
  logic  out_status;
  logic  out_last_of_run;

  bond_item_t  bonds_pending[$];
  bond_item_t  on_offer;
  angle_t      angles_due[$];
  atom_t       tbl_first[Bonds];
  atom_t       tbl_second[Bonds];
  int unsigned tbl_count    = 0;
  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned idle_cycles  = 0;
  int unsigned errors       = 0;
  int unsigned rx_hold_cnt  = 0;
  logic        rx_hold_kick = 1'b0;

  bond_angle_finder_unit #(
    .MAX_BONDS(Bonds)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_atom_first   (in_atom_first),
    .in_atom_second  (in_atom_second),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_end_atom_one(out_end_atom_one),
    .out_center_atom (out_center_atom),
    .out_end_atom_two(out_end_atom_two),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic atom_t any_atom();
    return atom_t'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic void queue_bond(logic func, atom_t a, atom_t b, int unsigned gap,
                                     bit stall = 1'b0, bit drain = 1'b0);
    bond_item_t it;
    it.func     = func;
    it.first    = a;
    it.second   = b;
    it.gap      = gap;
    it.rx_stall = stall;
    it.drain    = drain;
    bonds_pending = {bonds_pending, it};
  endfunction

  function automatic void push_angle(atom_t e1, atom_t c, atom_t e2, logic st);
    angle_t a;
    a.end_one = e1;
    a.center  = c;
    a.end_two = e2;
    a.status  = st;
    a.last    = 1'b0;
    angles_due = {angles_due, a};
  endfunction

  function automatic void find_angles(logic func, atom_t na, atom_t nb);
    int unsigned base;
    base = angles_due.size();
    if (func == FuncClear) begin
      tbl_count = 0;
    end else if (tbl_count >= Bonds) begin
      push_angle('0, '0, '0, StatFull);
    end else begin
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (tbl_first[i] == na) push_angle(tbl_second[i], tbl_first[i], nb, StatAngle);
        else if (tbl_first[i] == nb) push_angle(tbl_second[i], tbl_first[i], na, StatAngle);
        else if (tbl_second[i] == na) push_angle(tbl_first[i], tbl_second[i], nb, StatAngle);
        else if (tbl_second[i] == nb) push_angle(tbl_first[i], tbl_second[i], na, StatAngle);
      end
      tbl_first[tbl_count]  = na;
      tbl_second[tbl_count] = nb;
      tbl_count++;
    end
    if (angles_due.size() > base) angles_due[angles_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : drive_bonds
    bit busy;
    bit kick;
    kick = 1'b0;
    busy = in_valid;
    if (!rst_n) begin
      busy        = 1'b0;
      idle_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        find_angles(on_offer.func, on_offer.first, on_offer.second);
        kick        = on_offer.rx_stall;
        busy        = 1'b0;
        idle_cycles = 0;
        items_taken++;
      end
      if (!busy && bonds_pending.size() != 0 && idle_cycles >= bonds_pending[0].gap &&
          !(bonds_pending[0].drain && angles_due.size() != 0)) begin
        on_offer = bonds_pending.pop_front();
        in_func        <= on_offer.func;
        in_atom_first  <= on_offer.first;
        in_atom_second <= on_offer.second;
        busy = 1'b1;
      end else if (!busy) begin
        idle_cycles++;
      end
    end
    in_valid     <= busy;
    rx_hold_kick <= kick;
  end

  // long receiver hold-off, started when a marked item is taken
  always @(posedge clk) begin
    if (!rst_n) rx_hold_cnt <= 0;
    else if (rx_hold_kick) rx_hold_cnt <= HoldCycles;
    else if (rx_hold_cnt != 0) rx_hold_cnt <= rx_hold_cnt - 1;
  end

  always @(posedge clk) begin : take_angles
    angle_t      want;
    int unsigned wait_left;
    bit          calm;
    if (!rst_n) begin
      wait_left = 0;
      calm      = 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          $error("unexpected item: %0h %0h %0h status %0b last %0b", out_end_atom_one,
                 out_center_atom, out_end_atom_two, out_status, out_last_of_run);
          errors++;
        end else begin
          want = angles_due.pop_front();
          if (out_end_atom_one !== want.end_one) begin
            $error("end_atom_one: expected %0h, got %0h", want.end_one, out_end_atom_one);
            errors++;
          end
          if (out_center_atom !== want.center) begin
            $error("center_atom: expected %0h, got %0h", want.center, out_center_atom);
            errors++;
          end
          if (out_end_atom_two !== want.end_two) begin
            $error("end_atom_two: expected %0h, got %0h", want.end_two, out_end_atom_two);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_status);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
            errors++;
          end
        end
        if ($urandom_range(0, 29) == 0) calm = !calm;
        wait_left = calm ? 0 : $urandom_range(0, 13);
      end
      out_ready <= (rx_hold_cnt == 0 && wait_left == 0);
      if (wait_left != 0) wait_left--;
    end
  end

  initial begin : run_bonds
    atom_t       pool[8];
    int unsigned n_pool;
    int unsigned n_adds;
    int unsigned rand_items;
    int unsigned gap_max;

    // directed: each match case, extremes, self and repeated bonds, clears
    queue_bond(FuncClear, 16'hFFFF, 16'hFFFF, 0);
    queue_bond(FuncAdd, 16'h0000, 16'hFFFF, 2);
    queue_bond(FuncAdd, 16'h0000, 16'h0005, 0);
    queue_bond(FuncAdd, 16'h0007, 16'h0000, 5);
    queue_bond(FuncAdd, 16'hFFFF, 16'h0009, 0);
    queue_bond(FuncAdd, 16'h0003, 16'h0005, 13);
    queue_bond(FuncAdd, 16'h0100, 16'h0200, 0);
    queue_bond(FuncAdd, 16'hFFFF, 16'hFFFF, 1);
    queue_bond(FuncAdd, 16'hFFFF, 16'hFFFF, 0);
    queue_bond(FuncAdd, 16'h0009, 16'h0003, 7);
    queue_bond(FuncClear, 16'h0000, 16'h0000, 0, 1'b0, 1'b1);
    queue_bond(FuncAdd, 16'h1234, 16'h5678, 0);
    queue_bond(FuncAdd, 16'h5678, 16'h1234, 3);
    queue_bond(FuncAdd, 16'hAAAA, 16'h5555, 0);

    // fill the table past full with a small pool; hold off the receiver early on
    rand_items = 0;
    for (int k = 0; k < 6; k++) pool[k] = any_atom();
    queue_bond(FuncClear, any_atom(), any_atom(), 0, 1'b0, 1'b1);
    rand_items++;
    for (int unsigned k = 0; k < Bonds + 3; k++) begin
      queue_bond(FuncAdd, pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)], 0, k == 10);
      rand_items++;
    end

    // molecules: small atom pools with some stray bonds, not always cleared first
    while (rand_items < 86) begin
      n_pool = $urandom_range(2, 8);
      foreach (pool[k]) pool[k] = any_atom();
      n_adds  = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
      if ($urandom_range(0, 4) != 0) begin
        queue_bond(FuncClear, any_atom(), any_atom(), $urandom_range(0, gap_max), 1'b0,
                   $urandom_range(0, 7) == 0);
        rand_items++;
      end
      repeat (n_adds) begin
        if ($urandom_range(0, 4) == 0)
          queue_bond(FuncAdd, any_atom(), any_atom(), $urandom_range(0, gap_max));
        else
          queue_bond(FuncAdd, pool[$urandom_range(0, n_pool - 1)],
                     pool[$urandom_range(0, n_pool - 1)], $urandom_range(0, gap_max));
        rand_items++;
      end
    end
    items_queued = bonds_pending.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (items_taken == items_queued);
    while (angles_due.size() != 0) @(posedge clk);
    repeat (Bonds + 16) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[bond_angle_finder_unit.f]
hdl/baf_pkg.sv
hdl/baf_ctrl.sv
hdl/baf_dpath.sv
hdl/bond_angle_finder_unit.sv
sim/bond_angle_finder_unit_tb.sv
